>>> hdl/pbd_pkg.sv
// ----------------------------------------------------------------------------
// pbd_pkg
// Shared types, widths, register indexes and filter coefficients of the
// pulse beat detector.
// ----------------------------------------------------------------------------
package pbd_pkg;

    localparam int HISTORY_DEPTH = 32;
    localparam int RING_AW       = $clog2(HISTORY_DEPTH);

    localparam int SAMPLE_W   = 18;
    localparam int DATA_W     = 16;
    localparam int ACC_W      = 32;
    localparam int DIFF_W     = 34;
    localparam int FRAC_BITS  = 15;
    localparam int Z_W        = 33;
    localparam int COEF_W     = 14;
    localparam int PROD_W     = 30;
    localparam int AMP_W      = 15;
    localparam int SHIFT_W    = 4;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 15;
    localparam int TAP_W      = 4;

    localparam int NUM_STEPS  = 12;
    localparam int CENTER_TAP = 11;
    localparam int RING_SPAN  = 22;

    localparam logic [CFG_IDX_W-1:0] CFG_AMP_LOW  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_AMP_HIGH = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_DC_SHIFT = 2'd2;

    localparam logic [AMP_W-1:0]   AMP_LOW_RESET  = 15'd20;
    localparam logic [AMP_W-1:0]   AMP_HIGH_RESET = 15'd1000;
    localparam logic [SHIFT_W-1:0] DC_SHIFT_RESET = 4'd4;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DIFF,
        ST_ACC,
        ST_EST,
        ST_MAC,
        ST_FIN
    } state_t;

    typedef struct packed {
        logic             capture;
        logic             do_diff;
        logic             do_acc;
        logic             do_est;
        logic             mac_en;
        logic             fin;
        logic [TAP_W-1:0] rd_idx;
        logic [TAP_W-1:0] mac_idx;
    } pbd_cmd_t;

    typedef struct packed {
        logic out_free;
    } pbd_status_t;

    typedef struct packed {
        logic                  valid;
        logic [CFG_IDX_W-1:0]  index;
        logic [CFG_DATA_W-1:0] data;
    } cfg_wr_t;

    function automatic logic [COEF_W-1:0] fir_coef(input logic [TAP_W-1:0] idx);
        logic [COEF_W-1:0] c;
        case (idx)
            4'd0:    c = 14'd172;
            4'd1:    c = 14'd321;
            4'd2:    c = 14'd579;
            4'd3:    c = 14'd927;
            4'd4:    c = 14'd1360;
            4'd5:    c = 14'd1858;
            4'd6:    c = 14'd2390;
            4'd7:    c = 14'd2916;
            4'd8:    c = 14'd3391;
            4'd9:    c = 14'd3768;
            4'd10:   c = 14'd4012;
            4'd11:   c = 14'd4096;
            default: c = 14'd0;
        endcase
        return c;
    endfunction

endpackage

>>> hdl/pbd_sample_if.sv
// ----------------------------------------------------------------------------
// pbd_sample_if
// Input channel carrying one infrared sample per transaction.
// ----------------------------------------------------------------------------
interface pbd_sample_if;
    logic                          valid;
    logic                          ready;
    logic [pbd_pkg::SAMPLE_W-1:0]  sample;

    modport source (output valid, output sample, input ready);
    modport sink   (input valid, input sample, output ready);
endinterface

>>> hdl/pbd_result_if.sv
// ----------------------------------------------------------------------------
// pbd_result_if
// Output channel carrying one detector result per transaction.
// ----------------------------------------------------------------------------
interface pbd_result_if;
    logic                               valid;
    logic                               ready;
    logic                               beat;
    logic signed [pbd_pkg::DATA_W-1:0]  ac_value;
    logic signed [pbd_pkg::DATA_W-1:0]  dc_estimate;

    modport source (output valid, output beat, output ac_value, output dc_estimate,
                    input ready);
    modport sink   (input valid, input beat, input ac_value, input dc_estimate,
                    output ready);
endinterface

>>> hdl/pbd_cfg_if.sv
// ----------------------------------------------------------------------------
// pbd_cfg_if
// Configuration write channel: register index and write data.
// ----------------------------------------------------------------------------
interface pbd_cfg_if;
    logic                            valid;
    logic                            ready;
    logic [pbd_pkg::CFG_IDX_W-1:0]   index;
    logic [pbd_pkg::CFG_DATA_W-1:0]  data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

>>> hdl/pulse_beat_detector.sv
// ----------------------------------------------------------------------------
// pulse_beat_detector
// Heartbeat detector for an infrared pulse signal: DC tracking, 23-tap
// low-pass FIR on the AC part and beat qualification at rising zero crossings.
//
//   Channel   Direction   Transaction carries
//   samples   in          sample
//   results   out         beat, ac_value, dc_estimate
//   cfg       in          index, data (always ready)
//
// An accepted sample steps through the DC update (ST_DIFF, ST_ACC), the ring
// write (ST_EST), the shared multiply-accumulate over the center tap and 11
// tap pairs (ST_MAC) and the load of the output register (ST_FIN). Only back
// in ST_IDLE is the next sample accepted, so samples never overlap in work.
// A result held by a low results.ready stalls the next result and then the input.
// Reset clears the history ring through per-entry valid bits at once.
// ----------------------------------------------------------------------------
module pulse_beat_detector (
    input  logic         clk,
    input  logic         rst_n,
    pbd_sample_if.sink   samples,
    pbd_result_if.source results,
    pbd_cfg_if.sink      cfg
);
    import pbd_pkg::*;

    pbd_cmd_t    cmd;
    pbd_status_t status;
    cfg_wr_t     cfg_wr;

    assign cfg.ready    = 1'b1;
    assign cfg_wr.valid = cfg.valid;
    assign cfg_wr.index = cfg.index;
    assign cfg_wr.data  = cfg.data;

    pbd_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (samples.valid),
        .in_ready (samples.ready),
        .status   (status),
        .cmd      (cmd)
    );

    pbd_datapath u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .status    (status),
        .cfg_wr    (cfg_wr),
        .in_sample (samples.sample),
        .out_valid (results.valid),
        .out_ready (results.ready),
        .out_beat  (results.beat),
        .out_ac    (results.ac_value),
        .out_dc    (results.dc_estimate)
    );

endmodule

>>> hdl/pbd_ram.sv
// ----------------------------------------------------------------------------
// pbd_ram
// Generic RAM with one write port and two registered read ports.
// ----------------------------------------------------------------------------
module pbd_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 32
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr_a,
    output logic [WIDTH-1:0]         rdata_a,
    input  logic [$clog2(DEPTH)-1:0] raddr_b,
    output logic [WIDTH-1:0]         rdata_b
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_a <= mem[raddr_a];
        rdata_b <= mem[raddr_b];
    end

endmodule

>>> hdl/pbd_ctrl.sv
// ----------------------------------------------------------------------------
// pbd_ctrl
// Sequencer of the pulse beat detector: steps one sample through the DC
// update, the ring write, the shared multiply-accumulate and the result.
// ----------------------------------------------------------------------------
module pbd_ctrl (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  pbd_pkg::pbd_status_t status,
    output pbd_pkg::pbd_cmd_t    cmd
);
    import pbd_pkg::*;

    state_t           state_reg, state_next;
    logic [TAP_W-1:0] idx_reg, idx_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            idx_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            idx_reg   <= idx_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        idx_next   = idx_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = ST_DIFF;
                end
            end
            ST_DIFF:
            begin
                state_next = ST_ACC;
            end
            ST_ACC:
            begin
                state_next = ST_EST;
            end
            ST_EST:
            begin
                idx_next   = '0;
                state_next = ST_MAC;
            end
            ST_MAC:
            begin
                idx_next = idx_reg + TAP_W'(1);
                if (idx_reg == TAP_W'(NUM_STEPS))
                begin
                    state_next = ST_FIN;
                end
            end
            ST_FIN:
            begin
                if (status.out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        in_ready    = 1'b0;
        cmd         = '0;
        cmd.rd_idx  = idx_reg;
        cmd.mac_idx = idx_reg - TAP_W'(1);
        case (state_reg)
            ST_IDLE:
            begin
                in_ready    = 1'b1;
                cmd.capture = in_valid;
            end
            ST_DIFF:
            begin
                cmd.do_diff = 1'b1;
            end
            ST_ACC:
            begin
                cmd.do_acc = 1'b1;
            end
            ST_EST:
            begin
                cmd.do_est = 1'b1;
            end
            ST_MAC:
            begin
                cmd.mac_en = (idx_reg != '0);
            end
            ST_FIN:
            begin
                cmd.fin = status.out_free;
            end
            default:
            begin
                in_ready = 1'b0;
            end
        endcase
    end

endmodule

>>> hdl/pbd_datapath.sv
// ----------------------------------------------------------------------------
// pbd_datapath
// DC tracker, AC history ring, shared FIR multiply-accumulate, zero-crossing
// amplitude tracking, configuration registers and the result register.
// ----------------------------------------------------------------------------
module pbd_datapath (
    input  logic                                clk,
    input  logic                                rst_n,
    input  pbd_pkg::pbd_cmd_t                   cmd,
    output pbd_pkg::pbd_status_t                status,
    input  pbd_pkg::cfg_wr_t                    cfg_wr,
    input  logic [pbd_pkg::SAMPLE_W-1:0]        in_sample,
    output logic                                out_valid,
    input  logic                                out_ready,
    output logic                                out_beat,
    output logic signed [pbd_pkg::DATA_W-1:0]   out_ac,
    output logic signed [pbd_pkg::DATA_W-1:0]   out_dc
);
    import pbd_pkg::*;

    function automatic logic [RING_AW-1:0] ring_addr(input logic [RING_AW-1:0] wp,
                                                     input logic [RING_AW:0] back);
        logic [RING_AW:0] base;
        base = {1'b0, wp};
        if (base < back)
        begin
            base = base + (RING_AW+1)'(HISTORY_DEPTH);
        end
        return RING_AW'(base - back);
    endfunction

    logic [AMP_W-1:0]          amp_low_reg;
    logic [AMP_W-1:0]          amp_high_reg;
    logic [SHIFT_W-1:0]        dc_shift_reg;

    logic [DATA_W-1:0]         s_reg;
    logic signed [ACC_W-1:0]   diff_reg;
    logic signed [ACC_W-1:0]   acc_reg;
    logic signed [DATA_W-1:0]  est_reg;
    logic signed [Z_W-1:0]     z_reg, z_next;
    logic [RING_AW-1:0]        wp_reg, wp_next;
    logic [HISTORY_DEPTH-1:0]  valid_reg;
    logic                      va_reg;
    logic                      vb_reg;

    logic signed [DATA_W-1:0]  filt_reg, cmax_reg, cmin_reg;
    logic                      pos_reg, neg_reg;
    logic signed [DATA_W-1:0]  cmax_next, cmin_next;
    logic                      pos_next, neg_next, beat_next;

    logic                      out_valid_reg;
    logic                      out_beat_reg;
    logic signed [DATA_W-1:0]  out_ac_reg;
    logic signed [DATA_W-1:0]  out_dc_reg;

    logic signed [DIFF_W-1:0]  s_shift, acc_ext, diff_full, diff_shr;
    logic signed [DATA_W-1:0]  est_now, ac_now;
    logic [RING_AW:0]          back_a, back_b;
    logic [RING_AW-1:0]        addr_a, addr_b;
    logic [DATA_W-1:0]         rdata_a, rdata_b;
    logic signed [DATA_W-1:0]  ha, hb, pair, operand;
    logic signed [COEF_W-1:0]  coef_s;
    logic signed [PROD_W-1:0]  prod;
    logic signed [DATA_W-1:0]  cur, amp;
    logic                      rising, falling;

    // DC tracker.
    assign s_shift   = $signed({3'b000, s_reg, {FRAC_BITS{1'b0}}});
    assign acc_ext   = DIFF_W'(acc_reg);
    assign diff_full = s_shift - acc_ext;
    assign diff_shr  = diff_full >>> dc_shift_reg;
    assign est_now   = acc_reg[FRAC_BITS+DATA_W-1:FRAC_BITS];
    assign ac_now    = $signed(s_reg - est_now);

    // History ring reads for the current tap pair.
    assign back_a = (RING_AW+1)'(cmd.rd_idx);
    assign back_b = (RING_AW+1)'(RING_SPAN) - back_a;
    assign addr_a = ring_addr(wp_reg, back_a);
    assign addr_b = ring_addr(wp_reg, back_b);

    pbd_ram #(
        .WIDTH (DATA_W),
        .DEPTH (HISTORY_DEPTH)
    ) u_ring (
        .clk     (clk),
        .we      (cmd.do_est),
        .waddr   (wp_reg),
        .wdata   (ac_now),
        .raddr_a (addr_a),
        .rdata_a (rdata_a),
        .raddr_b (addr_b),
        .rdata_b (rdata_b)
    );

    // Shared multiply-accumulate. The center tap enters alone.
    assign ha      = va_reg ? $signed(rdata_a) : '0;
    assign hb      = vb_reg ? $signed(rdata_b) : '0;
    assign pair    = ha + hb;
    assign operand = (cmd.mac_idx == TAP_W'(CENTER_TAP)) ? ha : pair;
    assign coef_s  = $signed(fir_coef(cmd.mac_idx));
    assign prod    = PROD_W'(operand) * PROD_W'(coef_s);

    always_comb
    begin
        z_next = z_reg;
        if (cmd.do_est)
        begin
            z_next = '0;
        end
        else if (cmd.mac_en)
        begin
            z_next = z_reg + Z_W'(prod);
        end
    end

    // Zero-crossing amplitude tracking.
    assign cur     = z_reg[FRAC_BITS+DATA_W-1:FRAC_BITS];
    assign amp     = cmax_reg - cmin_reg;
    assign rising  = (filt_reg < 0) && (cur >= 0);
    assign falling = (filt_reg > 0) && (cur <= 0);

    always_comb
    begin
        pos_next  = pos_reg;
        neg_next  = neg_reg;
        cmax_next = cmax_reg;
        cmin_next = cmin_reg;
        beat_next = 1'b0;
        if (rising)
        begin
            pos_next  = 1'b1;
            neg_next  = 1'b0;
            cmax_next = '0;
            beat_next = (amp > $signed({1'b0, amp_low_reg}))
                     && (amp < $signed({1'b0, amp_high_reg}));
        end
        if (falling)
        begin
            pos_next  = 1'b0;
            neg_next  = 1'b1;
            cmin_next = '0;
        end
        if (pos_next && (cur > filt_reg))
        begin
            cmax_next = cur;
        end
        if (neg_next && (cur < filt_reg))
        begin
            cmin_next = cur;
        end
    end

    assign wp_next = (wp_reg == RING_AW'(HISTORY_DEPTH - 1)) ? '0 : wp_reg + RING_AW'(1);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            amp_low_reg   <= AMP_LOW_RESET;
            amp_high_reg  <= AMP_HIGH_RESET;
            dc_shift_reg  <= DC_SHIFT_RESET;
            acc_reg       <= '0;
            wp_reg        <= '0;
            valid_reg     <= '0;
            va_reg        <= 1'b0;
            vb_reg        <= 1'b0;
            filt_reg      <= '0;
            cmax_reg      <= '0;
            cmin_reg      <= '0;
            pos_reg       <= 1'b0;
            neg_reg       <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_wr.valid)
            begin
                case (cfg_wr.index)
                    CFG_AMP_LOW:  amp_low_reg  <= cfg_wr.data;
                    CFG_AMP_HIGH: amp_high_reg <= cfg_wr.data;
                    CFG_DC_SHIFT: dc_shift_reg <= cfg_wr.data[SHIFT_W-1:0];
                    default:      amp_low_reg  <= amp_low_reg;
                endcase
            end
            if (cmd.do_acc)
            begin
                acc_reg <= acc_reg + diff_reg;
            end
            if (cmd.do_est)
            begin
                valid_reg[wp_reg] <= 1'b1;
            end
            va_reg <= valid_reg[addr_a];
            vb_reg <= valid_reg[addr_b];
            if (cmd.fin)
            begin
                wp_reg   <= wp_next;
                filt_reg <= cur;
                cmax_reg <= cmax_next;
                cmin_reg <= cmin_next;
                pos_reg  <= pos_next;
                neg_reg  <= neg_next;
            end
            if (cmd.fin)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            s_reg <= in_sample[DATA_W-1:0];
        end
        if (cmd.do_diff)
        begin
            diff_reg <= diff_shr[ACC_W-1:0];
        end
        if (cmd.do_est)
        begin
            est_reg <= est_now;
        end
        z_reg <= z_next;
        if (cmd.fin)
        begin
            out_beat_reg <= beat_next;
            out_ac_reg   <= cur;
            out_dc_reg   <= est_reg;
        end
    end

    assign status.out_free = !out_valid_reg || out_ready;
    assign out_valid       = out_valid_reg;
    assign out_beat        = out_beat_reg;
    assign out_ac          = out_ac_reg;
    assign out_dc          = out_dc_reg;

endmodule

>>> hdl/pbd_checker.sv
// ----------------------------------------------------------------------------
// pbd_checker
// Port-level checks of the pulse beat detector, bound to the top level.
// ----------------------------------------------------------------------------
module pbd_checker (
    input logic                               clk,
    input logic                               rst_n,
    input logic                               in_valid,
    input logic                               in_ready,
    input logic                               out_valid,
    input logic                               out_ready,
    input logic                               out_beat,
    input logic signed [pbd_pkg::DATA_W-1:0]  out_ac,
    input logic signed [pbd_pkg::DATA_W-1:0]  out_dc
);
    import pbd_pkg::*;

    logic       in_acc, out_acc;
    logic [1:0] pending_reg;

    assign in_acc  = in_valid && in_ready;
    assign out_acc = out_valid && out_ready;

    // Count of accepted samples whose results have not been delivered.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pending_reg <= '0;
        end
        else
        begin
            pending_reg <= pending_reg + 2'(in_acc) - 2'(out_acc);
        end
    end

    a_one_in_work: assert property (@(posedge clk) disable iff (!rst_n)
        in_acc |=> !in_ready)
        else $error("A second sample was accepted while one was in work.");

    a_no_spurious: assert property (@(posedge clk) disable iff (!rst_n)
        out_acc |-> (pending_reg != 2'd0))
        else $error("A result was delivered without a pending sample.");

    a_pending_bound: assert property (@(posedge clk) disable iff (!rst_n)
        pending_reg != 2'd3)
        else $error("More than two samples are pending.");

    a_valid_holds: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_ready) |=> out_valid)
        else $error("A stalled result transaction was dropped.");

    a_payload_holds: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_ready) |=> $stable({out_beat, out_ac, out_dc}))
        else $error("A stalled result changed its payload.");

endmodule

bind pulse_beat_detector pbd_checker u_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (samples.valid),
    .in_ready  (samples.ready),
    .out_valid (results.valid),
    .out_ready (results.ready),
    .out_beat  (results.beat),
    .out_ac    (results.ac_value),
    .out_dc    (results.dc_estimate)
);

>>> test/pbd_beat_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pbd_beat_checker
// Passive scoreboard for the pulse beat detector. It watches the sample,
// result and configuration channels and keeps its own model of the DC
// tracker, the 23-tap FIR ring and the zero-crossing beat logic. For each
// accepted sample it queues the expected result. Each accepted result is
// checked field by field against the oldest queued one. The mismatch count
// and the number of outstanding results go to the testbench top.
// ----------------------------------------------------------------------------
module pbd_beat_checker (
    input  logic  clk,
    input  logic  rst_n,
    pbd_sample_if samples,
    pbd_result_if results,
    pbd_cfg_if    cfg,
    output int    mismatch_count,
    output int    results_pending
);
    import pbd_pkg::*;

    localparam int MAX_PRINTED = 100;
    localparam int SIDE_TAPS   = 11;
    localparam int CENTER_COEF = 4096;
    localparam int SIDE_COEF [SIDE_TAPS] =
        '{172, 321, 579, 927, 1360, 1858, 2390, 2916, 3391, 3768, 4012};

    typedef struct packed {
        logic                     beat;
        logic signed [DATA_W-1:0] ac_value;
        logic signed [DATA_W-1:0] dc_estimate;
    } beat_result_t;

    beat_result_t expected_results[$];

    logic [AMP_W-1:0]         amp_low;
    logic [AMP_W-1:0]         amp_high;
    logic [SHIFT_W-1:0]       dc_shift;
    logic signed [ACC_W-1:0]  dc_acc;
    logic signed [DATA_W-1:0] ac_ring [HISTORY_DEPTH];
    logic [RING_AW-1:0]       ring_pos;
    logic signed [DATA_W-1:0] filt_last;
    logic signed [DATA_W-1:0] peak_max;
    logic signed [DATA_W-1:0] peak_min;
    logic                     in_rise;
    logic                     in_fall;
    int                       result_index;

    task automatic report_mismatch(input string what);
        if (mismatch_count < MAX_PRINTED)
            $display("MISMATCH at %0t ns, result %0d: %s", $time, result_index, what);
        mismatch_count++;
    endtask

    task automatic reset_model();
        amp_low   = AMP_LOW_RESET;
        amp_high  = AMP_HIGH_RESET;
        dc_shift  = DC_SHIFT_RESET;
        dc_acc    = '0;
        ring_pos  = '0;
        filt_last = '0;
        peak_max  = '0;
        peak_min  = '0;
        in_rise   = 1'b0;
        in_fall   = 1'b0;
        for (int i = 0; i < HISTORY_DEPTH; i++)
            ac_ring[i] = '0;
        expected_results.delete();
        mismatch_count = 0;
        result_index   = 0;
    endtask

    task automatic apply_write(input logic [CFG_IDX_W-1:0] idx,
                               input logic [CFG_DATA_W-1:0] value);
        case (idx)
            CFG_AMP_LOW:  amp_low  = value[AMP_W-1:0];
            CFG_AMP_HIGH: amp_high = value[AMP_W-1:0];
            CFG_DC_SHIFT: dc_shift = value[SHIFT_W-1:0];
            default:      ;
        endcase
    endtask

    function automatic logic signed [DATA_W-1:0] ring_tap(input int back);
        return ac_ring[RING_AW'(int'(ring_pos) - back)];
    endfunction

    function automatic beat_result_t predict_result(input logic [SAMPLE_W-1:0] raw);
        beat_result_t             r;
        longint                   s;
        longint                   diff;
        longint                   z;
        logic signed [DATA_W-1:0] est;
        logic signed [DATA_W-1:0] ac;
        logic signed [DATA_W-1:0] prev;
        logic signed [DATA_W-1:0] cur;
        logic signed [DATA_W-1:0] pair;
        logic signed [DATA_W-1:0] amp;
        s      = longint'(raw[DATA_W-1:0]);
        diff   = (s <<< FRAC_BITS) - longint'(dc_acc);
        dc_acc = ACC_W'(longint'(dc_acc) + (diff >>> dc_shift));
        est    = DATA_W'(longint'(dc_acc) >>> FRAC_BITS);
        ac     = DATA_W'(s - longint'(est));

        prev              = filt_last;
        ac_ring[ring_pos] = ac;
        z = longint'(CENTER_COEF) * longint'(ring_tap(CENTER_TAP));
        for (int i = 0; i < SIDE_TAPS; i++)
        begin
            pair = DATA_W'(longint'(ring_tap(i)) + longint'(ring_tap(RING_SPAN - i)));
            z += longint'(SIDE_COEF[i]) * longint'(pair);
        end
        ring_pos  = ring_pos + 1'b1;
        cur       = DATA_W'(z >>> FRAC_BITS);
        filt_last = cur;

        r.beat = 1'b0;
        if (prev < 0 && cur >= 0)
        begin
            amp      = DATA_W'(int'(peak_max) - int'(peak_min));
            in_rise  = 1'b1;
            in_fall  = 1'b0;
            peak_max = '0;
            r.beat   = (int'(amp) > int'(amp_low)) && (int'(amp) < int'(amp_high));
        end
        if (prev > 0 && cur <= 0)
        begin
            in_rise  = 1'b0;
            in_fall  = 1'b1;
            peak_min = '0;
        end
        if (in_rise && cur > prev)
            peak_max = cur;
        if (in_fall && cur < prev)
            peak_min = cur;

        r.ac_value    = cur;
        r.dc_estimate = est;
        return r;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin : monitor
        beat_result_t want;
        if (!rst_n)
        begin
            reset_model();
        end
        else
        begin
            if (cfg.valid && cfg.ready)
                apply_write(cfg.index, cfg.data);
            if (samples.valid && samples.ready)
                expected_results.push_back(predict_result(samples.sample));
            if (results.valid && results.ready)
            begin
                if (expected_results.size() == 0)
                begin
                    report_mismatch("result transaction with no sample outstanding");
                end
                else
                begin
                    want = expected_results.pop_front();
                    if (results.beat !== want.beat)
                        report_mismatch($sformatf("beat: got %0b, expected %0b",
                                                  results.beat, want.beat));
                    if (results.ac_value !== want.ac_value)
                        report_mismatch($sformatf("ac_value: got %0d, expected %0d",
                                                  results.ac_value, want.ac_value));
                    if (results.dc_estimate !== want.dc_estimate)
                        report_mismatch($sformatf("dc_estimate: got %0d, expected %0d",
                                                  results.dc_estimate, want.dc_estimate));
                end
                result_index++;
            end
        end
        results_pending = expected_results.size();
    end

endmodule

>>> test/tb_pulse_beat_detector.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_pulse_beat_detector
// Stimulus and verdict for the pulse beat detector. A short directed run
// covers sample extremes, wide samples, a zero and a masked DC shift and a
// write to an unmapped register. Then phases of pulse-like waveforms mixed
// with noise run under varied thresholds, DC rates and idling patterns.
// One phase holds off the result channel until the block stalls its input.
// The checker beside the block predicts and compares every result.
// ----------------------------------------------------------------------------
module tb_pulse_beat_detector;
    import pbd_pkg::*;

    localparam logic [CFG_IDX_W-1:0] CFG_UNMAPPED = 2'd3;

    localparam int RESET_CYCLES     = 12;
    localparam int RANDOM_PER_PHASE = 152;
    localparam int NUM_PHASES       = 10;
    localparam int PRESSURE_PHASE   = 4;
    localparam int PRESSURE_ITEMS   = 12;
    localparam int HOLD_CYCLES      = 300;
    localparam int DRAIN_LIMIT      = 20000;
    localparam int SETTLE_CYCLES    = 40;
    localparam int TIMEOUT_NS       = 2000000;

    logic clk   = 1'b0;
    logic rst_n = 1'b0;

    int mismatch_count;
    int results_pending;
    int sender_idle_pct    = 0;
    int receiver_stall_pct = 0;
    int hold_seq           = 0;

    always #1 clk = ~clk;

    pbd_sample_if sample_ch ();
    pbd_result_if result_ch ();
    pbd_cfg_if    cfg_ch ();

    pulse_beat_detector DUT (
        .clk     (clk),
        .rst_n   (rst_n),
        .samples (sample_ch),
        .results (result_ch),
        .cfg     (cfg_ch)
    );

    pbd_beat_checker u_checker (
        .clk             (clk),
        .rst_n           (rst_n),
        .samples         (sample_ch),
        .results         (result_ch),
        .cfg             (cfg_ch),
        .mismatch_count  (mismatch_count),
        .results_pending (results_pending)
    );

    task automatic send_sample(input logic [SAMPLE_W-1:0] value);
        while ($urandom_range(0, 99) < sender_idle_pct)
        begin
            sample_ch.valid <= 1'b0;
            @(posedge clk);
        end
        sample_ch.valid  <= 1'b1;
        sample_ch.sample <= value;
        do @(negedge clk); while (!sample_ch.ready);
        @(posedge clk);
    endtask

    task automatic write_register(input logic [CFG_IDX_W-1:0] idx,
                                  input logic [CFG_DATA_W-1:0] value);
        cfg_ch.valid <= 1'b1;
        cfg_ch.index <= idx;
        cfg_ch.data  <= value;
        do @(negedge clk); while (!cfg_ch.ready);
        @(posedge clk);
        cfg_ch.valid <= 1'b0;
        @(posedge clk);
    endtask

    // The count is read at falling edges only, after the checker has
    // taken in the transaction of the preceding rising edge.
    task automatic wait_for_results();
        int n;
        sample_ch.valid <= 1'b0;
        n = 0;
        do
        begin
            @(negedge clk);
            n++;
        end
        while (n < DRAIN_LIMIT && results_pending != 0);
        @(posedge clk);
    endtask

    task automatic apply_settings(input int low, input int high, input int shift_raw);
        write_register(CFG_AMP_LOW, CFG_DATA_W'(low));
        write_register(CFG_AMP_HIGH, CFG_DATA_W'(high));
        write_register(CFG_DC_SHIFT, CFG_DATA_W'(shift_raw));
    endtask

    task automatic configure_phase(input int phase);
        case (phase)
            0: apply_settings(20, 1000, 4);
            1: apply_settings(0, 32767, 1);
            2: apply_settings(32767, 0, 8);
            3: apply_settings(5, 300, 0);
            4: apply_settings(50, 5000, 15);
            5: apply_settings(10, 2000, 15'h7FF3);
            7: apply_settings(0, 32767, 9);
            9:
            begin
                apply_settings(100, 800, 6);
                write_register(CFG_UNMAPPED, CFG_DATA_W'($urandom));
            end
            default: apply_settings($urandom_range(0, 400), $urandom_range(200, 32767),
                                    $urandom_range(0, 32767));
        endcase
        case (phase % 4)
            0:
            begin
                sender_idle_pct    = 0;
                receiver_stall_pct = 0;
            end
            1:
            begin
                sender_idle_pct    = 70;
                receiver_stall_pct = 0;
            end
            2:
            begin
                sender_idle_pct    = 0;
                receiver_stall_pct = 70;
            end
            default:
            begin
                sender_idle_pct    = 27;
                receiver_stall_pct = 27;
            end
        endcase
    endtask

    task automatic run_directed();
        send_sample(18'h00000);
        send_sample(18'h3FFFF);
        send_sample(18'h0FFFF);
        send_sample(18'h10000);
        send_sample(18'h08000);
        send_sample(18'h07FFF);
        send_sample(18'h2FFFF);
        send_sample(18'h00001);
        send_sample(18'h0FFFF);
        send_sample(18'h00000);
        send_sample(18'h18000);
        send_sample(18'h3FFFF);
        wait_for_results();
        write_register(CFG_DC_SHIFT, '0);
        write_register(CFG_UNMAPPED, '1);
        send_sample(18'h0FFFF);
        send_sample(18'h00000);
        send_sample(18'h08000);
        send_sample(18'h37FFF);
        send_sample(18'h00000);
        send_sample(18'h0FFFF);
        wait_for_results();
        write_register(CFG_DC_SHIFT, '1);
        send_sample(18'h3FFFF);
        send_sample(18'h00000);
        send_sample(18'h0FFFF);
        send_sample(18'h28000);
        send_sample(18'h07FFF);
        send_sample(18'h00000);
    endtask

    task automatic run_random(input int count);
        int                  sent;
        int                  seg_len;
        int                  period;
        int                  amp;
        int                  base;
        int                  noise_amp;
        int                  noise;
        int                  ramp;
        int                  level;
        logic [SAMPLE_W-1:0] value;
        sent = 0;
        while (sent < count)
        begin
            seg_len = $urandom_range(40, 160);
            if ($urandom_range(0, 99) < 15)
            begin
                for (int k = 0; k < seg_len && sent < count; k++)
                begin
                    send_sample(SAMPLE_W'($urandom));
                    sent++;
                end
            end
            else
            begin
                period = $urandom_range(8, 64);
                base   = $urandom_range(0, 65535);
                case ($urandom_range(0, 3))
                    0:       amp = $urandom_range(1, 40);
                    1, 2:    amp = $urandom_range(40, 800);
                    default: amp = $urandom_range(800, 30000);
                endcase
                noise_amp = $urandom_range(0, amp / 8);
                for (int k = 0; k < seg_len && sent < count; k++)
                begin
                    ramp  = k % period;
                    if (ramp >= period / 2)
                        ramp = period - ramp;
                    noise = $urandom_range(0, 2 * noise_amp);
                    level = base + (ramp * 2 * amp) / period - amp / 2 + noise - noise_amp;
                    value = SAMPLE_W'($urandom);
                    value[DATA_W-1:0] = DATA_W'(level);
                    send_sample(value);
                    sent++;
                end
            end
        end
    endtask

    initial
    begin : result_sink
        int hold_left;
        int hold_seen;
        hold_left = 0;
        hold_seen = 0;
        result_ch.ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_seq != hold_seen)
            begin
                hold_seen = hold_seq;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                result_ch.ready <= 1'b0;
            end
            else
            begin
                result_ch.ready <= ($urandom_range(0, 99) >= receiver_stall_pct);
            end
        end
    end

    initial
    begin : stimulus
        sample_ch.valid  <= 1'b0;
        sample_ch.sample <= '0;
        cfg_ch.valid     <= 1'b0;
        cfg_ch.index     <= '0;
        cfg_ch.data      <= '0;
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        run_directed();
        for (int phase = 0; phase < NUM_PHASES; phase++)
        begin
            wait_for_results();
            configure_phase(phase);
            run_random(RANDOM_PER_PHASE);
            if (phase == PRESSURE_PHASE)
            begin
                sender_idle_pct = 0;
                hold_seq++;
                for (int k = 0; k < PRESSURE_ITEMS; k++)
                    send_sample(SAMPLE_W'($urandom));
            end
        end

        wait_for_results();
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (mismatch_count == 0 && results_pending == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

    initial
    begin : watchdog
        #(TIMEOUT_NS);
        $display("RESULT: ERROR");
        $finish;
    end

endmodule
